### rtl/mnde_pkg.sv
// Shared types and constants for the max neighbor difference edge block.
`timescale 1ns / 1ps
`default_nettype none

package mnde_pkg;

   // Pixel and result word widths
   localparam int PIX_W = 8;

   // Configuration register indexes and reset values
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_FRAME_WIDTH  = 1'b0;
   localparam csr_index_type CSR_FRAME_HEIGHT = 1'b1;
   localparam int FRAME_WIDTH_W  = 12;
   localparam int FRAME_HEIGHT_W = 13;
   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

   // Input word kinds carried on tuser
   typedef logic [0:0] op_type;
   localparam op_type OP_PIXEL = 1'b0;
   localparam op_type OP_DRAIN = 1'b1;

   // Result queue sizing
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   // Per-word control that travels with a pixel down the window pipeline
   typedef struct packed {
      logic emit;
      logic last;
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
   } edge_ctl_type;

endpackage

`default_nettype wire

### rtl/mnde_line_store.sv
// Dual row store in one synchronous memory with read-after-write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module mnde_line_store #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       rd_en,
   input  wire logic [ADDR_W-1:0]          rd_addr,
   input  wire logic                       wr_en,
   input  wire logic [ADDR_W-1:0]          wr_addr,
   input  wire logic [mnde_pkg::PIX_W-1:0] wr_pix,
   output logic      [mnde_pkg::PIX_W-1:0] upper_pix,
   output logic      [mnde_pkg::PIX_W-1:0] lower_pix
);

   localparam int PW = mnde_pkg::PIX_W;

   // Each entry holds {upper row, lower row} for one column
   logic [2*PW-1:0] mem [DEPTH];
   logic [2*PW-1:0] rd_q_ff;
   logic            fwd_hit_ff;
   logic [2*PW-1:0] fwd_data_ff;
   logic [2*PW-1:0] wr_data;
   logic [2*PW-1:0] rd_data;

   // Use the write still landing when the same column was read in that cycle
   assign rd_data   = fwd_hit_ff ? fwd_data_ff : rd_q_ff;
   assign upper_pix = rd_data[2*PW-1:PW];
   assign lower_pix = rd_data[PW-1:0];

   // Lower row moves up, new pixel becomes the lower row
   assign wr_data = {rd_data[PW-1:0], wr_pix};

   // Read and write the memory
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      fwd_data_ff <= wr_data;
   end

   // Track a read that collides with the write in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= rd_en && wr_en && (rd_addr == wr_addr);
      end
   end

endmodule

`default_nettype wire

### rtl/mnde_window.sv
// 3x3 window, masked neighbor differences and maximum over them.
`timescale 1ns / 1ps
`default_nettype none

module mnde_window (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       s1_valid,
   input  wire mnde_pkg::edge_ctl_type     s1_ctl,
   input  wire logic [mnde_pkg::PIX_W-1:0] s1_pix,
   input  wire logic [mnde_pkg::PIX_W-1:0] upper_pix,
   input  wire logic [mnde_pkg::PIX_W-1:0] lower_pix,
   output logic                            res_push,
   output logic      [mnde_pkg::PIX_W-1:0] res_edge,
   output logic                            res_last,
   output logic      [1:0]                 inflight
);

   localparam int PW = mnde_pkg::PIX_W;

   logic [PW-1:0]          win_ff [9];
   logic [PW-1:0]          win_in [9];
   logic                   s2_valid_ff;
   mnde_pkg::edge_ctl_type s2_ctl_ff;
   logic                   s3_valid_ff;
   logic                   s3_last_ff;
   logic [PW-1:0]          s3_diff_ff [9];
   logic [PW-1:0]          s3_diff_in [9];
   logic [PW-1:0]          best;

   // Shift the window left and bring in the new column
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3+0] = win_ff[r*3+1];
         win_in[r*3+1] = win_ff[r*3+2];
      end
      win_in[2] = upper_pix;
      win_in[5] = lower_pix;
      win_in[8] = s1_pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (s1_valid) begin
         win_ff <= win_in;
      end
   end

   // Absolute differences to the centre, dropped where the neighbor is off frame
   always_comb begin
      logic ok;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            ok = !(r == 1 && c == 1)
                 && !(r == 0 && !s2_ctl_ff.top_ok)
                 && !(r == 2 && !s2_ctl_ff.bot_ok)
                 && !(c == 0 && !s2_ctl_ff.left_ok)
                 && !(c == 2 && !s2_ctl_ff.right_ok);
            if (!ok) begin
               s3_diff_in[r*3+c] = '0;
            end else if (win_ff[r*3+c] > win_ff[4]) begin
               s3_diff_in[r*3+c] = win_ff[r*3+c] - win_ff[4];
            end else begin
               s3_diff_in[r*3+c] = win_ff[4] - win_ff[r*3+c];
            end
         end
      end
   end

   // Advance the result stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid && s1_ctl.emit;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_ctl_ff  <= s1_ctl;
      s3_last_ff <= s2_ctl_ff.last;
      s3_diff_ff <= s3_diff_in;
   end

   // Largest difference
   always_comb begin
      best = '0;
      for (int k = 0; k < 9; k++) begin
         if (s3_diff_ff[k] > best) begin
            best = s3_diff_ff[k];
         end
      end
   end

   assign res_push = s3_valid_ff;
   assign res_edge = best;
   assign res_last = s3_last_ff;
   assign inflight = {1'b0, s2_valid_ff} + {1'b0, s3_valid_ff};

   // A result leaves once an emitting word entering the window has passed the s2 and s3 stages
   a_push_follows: assert property (@(posedge clock) disable iff (reset)
      res_push |-> $past(s1_valid, 2) && $past(s1_ctl.emit, 2))
      else $error("result without an emitting word two cycles earlier");

   // The centre never differs from itself, so a lone pixel gives zero
   a_lone_zero: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_ctl_ff.top_ok && !s2_ctl_ff.bot_ok && !s2_ctl_ff.left_ok
      && !s2_ctl_ff.right_ok |=> res_edge == '0)
      else $error("pixel without neighbors gave a nonzero edge");

   // The window only moves on a processed word
   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_valid |=> $stable(win_ff[4]) && $stable(win_ff[8]))
      else $error("window moved without a word");

endmodule

`default_nettype wire

### rtl/mnde_out_fifo.sv
// Result queue that decouples the window pipeline from the result channel.
`timescale 1ns / 1ps
`default_nettype none

module mnde_out_fifo (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   input  wire logic [mnde_pkg::PIX_W-1:0]       push_edge,
   input  wire logic                             push_last,
   input  wire logic                             pop_ready,
   output logic                                  out_valid,
   output logic      [mnde_pkg::PIX_W-1:0]       out_edge,
   output logic                                  out_last,
   output logic      [mnde_pkg::FIFO_CNT_W-1:0]  count
);

   localparam int PW  = mnde_pkg::PIX_W;
   localparam int PTW = mnde_pkg::FIFO_PTR_W;
   localparam int CW  = mnde_pkg::FIFO_CNT_W;

   logic [PW:0]    slot [mnde_pkg::FIFO_DEPTH];
   logic [PTW-1:0] wr_ptr_ff;
   logic [PTW-1:0] rd_ptr_ff;
   logic [CW-1:0]  count_ff;
   logic           pop;

   assign out_valid = (count_ff != '0);
   assign out_edge  = slot[rd_ptr_ff][PW-1:0];
   assign out_last  = slot[rd_ptr_ff][PW];
   assign count     = count_ff;
   assign pop       = out_valid && pop_ready;

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         slot[wr_ptr_ff] <= {push_last, push_edge};
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTW'(1);
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + CW'(1);
            2'b01:   count_ff <= count_ff - CW'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/max_neighbor_difference_edge.sv
// Top level: position tracking, line store, window pipeline and result queue.
// Timing: the result for a pixel is due on the word that arrives frame_width + 1
// words later and reaches rsp_tvalid via the s1, s2, s3 registers and the queue.
// Throughput: one word per cycle while the 8-entry result queue credit allows,
// set by the single read and write port of the line store memory.
// Reset: synchronous; clears positions, window and queue; registers return to
// 640 x 480. The line store holds no reset value and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module max_neighbor_difference_edge #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] pixel
   input  wire logic        req_tuser,   // [0] operation
   // Result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,   // [7:0] edge_value
   output logic             rsp_tlast,
   // Configuration writes
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [12:0] csr_wdata
);

   localparam int PW     = mnde_pkg::PIX_W;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT) + 2;
   localparam int WC_W   = ((COL_W + 1 > mnde_pkg::FRAME_WIDTH_W) ? COL_W + 1
                            : mnde_pkg::FRAME_WIDTH_W) + 1;
   localparam int HC_W   = ((ROW_W > mnde_pkg::FRAME_HEIGHT_W) ? ROW_W
                            : mnde_pkg::FRAME_HEIGHT_W) + 1;
   localparam int CRED_W = mnde_pkg::FIFO_CNT_W + 1;

   logic [mnde_pkg::FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [mnde_pkg::FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [WC_W-1:0] w_eff;
   logic [WC_W-1:0] fw_ext;
   logic [HC_W-1:0] h_eff;
   logic [HC_W-1:0] fh_ext;

   logic [COL_W-1:0] in_col_ff,  in_col_in;
   logic [ROW_W-1:0] in_row_ff,  in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic             frame_done_ff, frame_done_in;

   logic                   accept;
   logic                   proc;
   logic                   col_wrap;
   logic                   ocol_wrap;
   logic [WC_W-1:0]        col_plus;
   logic [WC_W-1:0]        ocol_plus;
   logic [HC_W-1:0]        row_plus;
   logic [HC_W-1:0]        orow_plus;
   mnde_pkg::edge_ctl_type ctl;

   logic                   s1_valid_ff;
   logic [COL_W-1:0]       s1_col_ff;
   logic [PW-1:0]          s1_pix_ff;
   mnde_pkg::edge_ctl_type s1_ctl_ff;

   logic [PW-1:0]                     upper_pix;
   logic [PW-1:0]                     lower_pix;
   logic                              res_push;
   logic [PW-1:0]                     res_edge;
   logic                              res_last;
   logic [1:0]                        win_inflight;
   logic [mnde_pkg::FIFO_CNT_W-1:0]   fifo_count;
   logic [CRED_W-1:0]                 credit_used;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= mnde_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= mnde_pkg::FRAME_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            mnde_pkg::CSR_FRAME_WIDTH:
               frame_width_ff <= csr_wdata[mnde_pkg::FRAME_WIDTH_W-1:0];
            mnde_pkg::CSR_FRAME_HEIGHT:
               frame_height_ff <= csr_wdata[mnde_pkg::FRAME_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the frame size to 1 .. maximum
   always_comb begin
      fw_ext = WC_W'(frame_width_ff);
      fh_ext = HC_W'(frame_height_ff);
      if (fw_ext == '0) begin
         w_eff = WC_W'(1);
      end else if (fw_ext > WC_W'(MAX_WIDTH)) begin
         w_eff = WC_W'(MAX_WIDTH);
      end else begin
         w_eff = fw_ext;
      end
      if (fh_ext == '0) begin
         h_eff = HC_W'(1);
      end else if (fh_ext > HC_W'(MAX_HEIGHT)) begin
         h_eff = HC_W'(MAX_HEIGHT);
      end else begin
         h_eff = fh_ext;
      end
   end

   // Hold input while the queue cannot take every result in flight
   assign credit_used = CRED_W'(fifo_count) + CRED_W'(s1_valid_ff && s1_ctl_ff.emit)
                        + CRED_W'(win_inflight);
   assign req_tready  = (credit_used < CRED_W'(mnde_pkg::FIFO_DEPTH));
   assign accept      = req_tvalid && req_tready;
   // Drop drain words before frame end and pixel words during drain
   assign proc        = accept && (req_tuser == frame_done_ff);

   // Position tracking for the incoming word and the result it releases
   always_comb begin
      col_plus  = WC_W'(in_col_ff) + WC_W'(1);
      row_plus  = HC_W'(in_row_ff) + HC_W'(1);
      ocol_plus = WC_W'(out_col_ff) + WC_W'(1);
      orow_plus = HC_W'(out_row_ff) + HC_W'(1);
      col_wrap  = (col_plus >= w_eff);
      ocol_wrap = (ocol_plus >= w_eff);

      ctl.emit     = (in_row_ff > ROW_W'(1)) || (in_row_ff == ROW_W'(1) && in_col_ff != '0);
      ctl.last     = (orow_plus >= h_eff) && ocol_wrap;
      ctl.top_ok   = (out_row_ff != '0);
      ctl.bot_ok   = (orow_plus < h_eff);
      ctl.left_ok  = (out_col_ff != '0);
      ctl.right_ok = !ocol_wrap;

      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      frame_done_in = frame_done_ff;

      if (proc) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = row_plus[ROW_W-1:0];
            if (req_tuser == mnde_pkg::OP_PIXEL && row_plus >= h_eff) begin
               frame_done_in = 1'b1;
            end
         end else begin
            in_col_in = col_plus[COL_W-1:0];
         end
         if (ctl.emit) begin
            priority if (ctl.last) begin
               in_col_in     = '0;
               in_row_in     = '0;
               out_col_in    = '0;
               out_row_in    = '0;
               frame_done_in = 1'b0;
            end else if (ocol_wrap) begin
               out_col_in = '0;
               out_row_in = orow_plus[ROW_W-1:0];
            end else begin
               out_col_in = ocol_plus[COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         frame_done_ff <= 1'b0;
      end else begin
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         frame_done_ff <= frame_done_in;
      end
   end

   // Stage the word alongside the line store read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= proc;
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff <= in_col_ff;
      s1_pix_ff <= (req_tuser == mnde_pkg::OP_DRAIN) ? '0 : req_tdata;
      s1_ctl_ff <= ctl;
   end

   mnde_line_store #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (proc),
      .rd_addr   (in_col_ff),
      .wr_en     (s1_valid_ff),
      .wr_addr   (s1_col_ff),
      .wr_pix    (s1_pix_ff),
      .upper_pix (upper_pix),
      .lower_pix (lower_pix)
   );

   mnde_window u_window (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid_ff),
      .s1_ctl    (s1_ctl_ff),
      .s1_pix    (s1_pix_ff),
      .upper_pix (upper_pix),
      .lower_pix (lower_pix),
      .res_push  (res_push),
      .res_edge  (res_edge),
      .res_last  (res_last),
      .inflight  (win_inflight)
   );

   mnde_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_edge (res_edge),
      .push_last (res_last),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_edge  (rsp_tdata),
      .out_last  (rsp_tlast),
      .count     (fifo_count)
   );

   // The final result of a frame clears every position
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      proc && ctl.emit && ctl.last |=> in_col_ff == '0 && in_row_ff == '0
      && out_col_ff == '0 && out_row_ff == '0 && !frame_done_ff)
      else $error("frame end did not clear positions");

   // An ignored word leaves the position state alone
   a_ignored_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !proc |=> $stable(in_col_ff) && $stable(in_row_ff)
      && $stable(frame_done_ff) && !s1_valid_ff)
      else $error("ignored word changed state");

   // Credit keeps the queue from overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push |-> fifo_count < mnde_pkg::FIFO_CNT_W'(mnde_pkg::FIFO_DEPTH))
      else $error("result pushed into a full queue");

endmodule

`default_nettype wire

### tb/tb_max_neighbor_difference_edge.sv
// Self-checking testbench for the 3x3 max neighbor difference edge block.
`timescale 1ns / 1ps

module tb_max_neighbor_difference_edge;

   localparam int MAX_W          = 2048;
   localparam int MAX_H          = 4096;
   localparam int HALF_PERIOD    = 10;
   localparam int SETTLE_CYCLES  = 12;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_WORDS    = 170;

   typedef struct packed {
      logic [7:0] mag;
      logic       last;
   } edge_result_type;

   typedef enum logic {ROW_WORD, ROW_SIZE} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      mnde_pkg::op_type op;
      logic [7:0]       pix;
      logic [11:0]      width_val;
      logic [12:0]      height_val;
      logic             has_res;
      logic [7:0]       mag;
      logic             last;
   } dir_row_type;

   // Block ports
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] pixel
   logic        req_tuser  = mnde_pkg::OP_PIXEL; // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // [7:0] edge_value
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [0:0]  csr_index  = mnde_pkg::CSR_FRAME_WIDTH;
   logic [12:0] csr_wdata  = 13'd0;

   // Shadow of the block state
   logic [11:0] cfg_width  = mnde_pkg::FRAME_WIDTH_RST;
   logic [12:0] cfg_height = mnde_pkg::FRAME_HEIGHT_RST;
   logic [7:0]  pd_upper [MAX_W] = '{default: 8'd0};
   logic [7:0]  pd_lower [MAX_W] = '{default: 8'd0};
   logic [7:0]  pd_win   [9]     = '{default: 8'd0};
   int unsigned pd_in_col     = 0;
   int unsigned pd_in_row     = 0;
   int unsigned pd_out_col    = 0;
   int unsigned pd_out_row    = 0;
   bit          pd_frame_done = 1'b0;
   bit          frame_closed  = 1'b0;

   edge_result_type due_edges [$];
   dir_row_type     dir_rows  [$];

   // Run control and statistics
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   logic hold_rsp     = 1'b0;
   int idle_cycles    = 0;
   int mismatch_count = 0;
   int words_sent     = 0;
   int words_used     = 0;
   int results_seen   = 0;
   int frames_done    = 0;
   int size_writes    = 0;

   max_neighbor_difference_edge #(
      .MAX_WIDTH (MAX_W),
      .MAX_HEIGHT(MAX_H)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR %s", $time, msg);
      mismatch_count++;
   endtask

   // Advance the shadow by one word; return 1 with the edge result when one is due
   function automatic bit max_diff_step(input mnde_pkg::op_type op,
                                        input logic [7:0] pix_in,
                                        output edge_result_type res);
      int unsigned w, h, col, best, diff;
      int r, c;
      bit drain, emit, top_ok, bot_ok, left_ok, right_ok;
      logic [7:0] pix, centre;
      res = '0;
      w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
      h = (cfg_height == 0) ? 1 : ((cfg_height > MAX_H) ? MAX_H : cfg_height);
      drain = (op == mnde_pkg::OP_DRAIN);
      // drop early drains and pixels that arrive while draining
      if (drain != pd_frame_done) return 1'b0;
      words_used++;
      pix = drain ? 8'd0 : pix_in;
      col = (pd_in_col >= MAX_W) ? MAX_W - 1 : pd_in_col;

      // shift the window and pull the new column from the line stores
      for (r = 0; r < 3; r++) begin
         pd_win[r*3]   = pd_win[r*3+1];
         pd_win[r*3+1] = pd_win[r*3+2];
      end
      pd_win[2] = pd_upper[col];
      pd_win[5] = pd_lower[col];
      pd_win[8] = pix;
      pd_upper[col] = pd_lower[col];
      pd_lower[col] = pix;

      emit = (pd_in_row > 1) || (pd_in_row == 1 && pd_in_col >= 1);
      if (pd_in_col + 1 >= w) begin
         pd_in_col = 0;
         pd_in_row++;
         if (!drain && pd_in_row >= h) pd_frame_done = 1'b1;
      end else begin
         pd_in_col++;
      end
      if (!emit) return 1'b0;

      // largest difference to the neighbors that lie inside the frame
      centre   = pd_win[4];
      top_ok   = pd_out_row >= 1;
      bot_ok   = pd_out_row + 1 < h;
      left_ok  = pd_out_col >= 1;
      right_ok = pd_out_col + 1 < w;
      best = 0;
      for (r = 0; r < 3; r++) begin
         if (r == 0 && !top_ok) continue;
         if (r == 2 && !bot_ok) continue;
         for (c = 0; c < 3; c++) begin
            if (r == 1 && c == 1) continue;
            if (c == 0 && !left_ok) continue;
            if (c == 2 && !right_ok) continue;
            diff = (pd_win[r*3+c] > centre) ? pd_win[r*3+c] - centre
                                             : centre - pd_win[r*3+c];
            if (diff > best) best = diff;
         end
      end
      res.mag  = best[7:0];
      res.last = (pd_out_row + 1 >= h) && (pd_out_col + 1 >= w);

      if (res.last) begin
         pd_in_col     = 0;
         pd_in_row     = 0;
         pd_out_col    = 0;
         pd_out_row    = 0;
         pd_frame_done = 1'b0;
         frame_closed  = 1'b1;
         frames_done++;
      end else if (pd_out_col + 1 >= w) begin
         pd_out_col = 0;
         pd_out_row++;
      end else begin
         pd_out_col++;
      end
      return 1'b1;
   endfunction

   // Offer one word, wait for it to be taken, then queue what it produces
   task automatic send_word(input mnde_pkg::op_type op, input logic [7:0] pix,
                            input bit typed, input bit typed_has,
                            input logic [7:0] typed_mag, input bit typed_last);
      edge_result_type res;
      bit has;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      has = max_diff_step(op, pix, res);
      if (typed) begin
         has      = typed_has;
         res.mag  = typed_mag;
         res.last = typed_last;
      end
      if (has) due_edges = {due_edges, res};
   endtask

   // Let the block go idle, then write both frame size registers
   task automatic set_frame_size(input int unsigned w, input int unsigned h);
      req_tvalid <= 1'b0;
      while (due_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= mnde_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= 13'(w);
      @(posedge clock);
      csr_index <= mnde_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= 13'(h);
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_width  = w[11:0];
      cfg_height = h[12:0];
      size_writes += 2;
   endtask

   // Stream one whole frame plus its drain, with a little noise mixed in
   task automatic run_frame(input int unsigned w, input int unsigned h, input bit resize);
      int style, level;
      logic [7:0] base, pix;
      mnde_pkg::op_type op;
      if (resize) set_frame_size(w, h);
      style = $urandom_range(2);
      base  = 8'($urandom_range(255));
      frame_closed = 1'b0;
      while (!frame_closed) begin
         if (!pd_frame_done)
            op = ($urandom_range(99) < 6) ? mnde_pkg::OP_DRAIN : mnde_pkg::OP_PIXEL;
         else
            op = ($urandom_range(99) < 6) ? mnde_pkg::OP_PIXEL : mnde_pkg::OP_DRAIN;
         case (style)
            0: pix = 8'($urandom_range(255));
            1: begin
               level = int'(base) + int'($urandom_range(6)) - 3;
               level = (level < 0) ? 0 : ((level > 255) ? 255 : level);
               pix   = 8'(level);
               base  = pix;
            end
            default: pix = $urandom_range(1) ? 8'hFF : 8'h00;
         endcase
         send_word(op, pix, 1'b0, 1'b0, 8'd0, 1'b0);
      end
   endtask

   function automatic void add_word(input mnde_pkg::op_type op, input logic [7:0] pix,
                                    input logic has_res, input logic [7:0] mag,
                                    input logic last);
      dir_row_type row;
      row = '{ROW_WORD, op, pix, 12'd0, 13'd0, has_res, mag, last};
      dir_rows = {dir_rows, row};
   endfunction

   function automatic void add_size(input logic [11:0] w, input logic [12:0] h);
      dir_row_type row;
      row = '{ROW_SIZE, mnde_pkg::OP_PIXEL, 8'd0, w, h, 1'b0, 8'd0, 1'b0};
      dir_rows = {dir_rows, row};
   endfunction

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      edge_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (due_edges.size() == 0) begin
            report_mismatch($sformatf("edge result %0d last %0b with nothing due",
                                      rsp_tdata, rsp_tlast));
         end else begin
            want = due_edges.pop_front();
            if (rsp_tdata != want.mag)
               report_mismatch($sformatf("edge value %0d, expected %0d",
                                         rsp_tdata, want.mag));
            if (rsp_tlast != want.last)
               report_mismatch($sformatf("last flag %0b, expected %0b",
                                         rsp_tlast, want.last));
         end
      end
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int send_pcts [4];
      int stall_pcts [4];
      int target, k;
      int unsigned w, h;
      bit resize;
      send_pcts  = '{0, 82, 0, 28};
      stall_pcts = '{0, 0, 82, 28};

      // Directed table: lone pixels, zero-sized registers, a 3x3 checkerboard
      add_word(mnde_pkg::OP_DRAIN, 8'h5A, 1'b0, 8'd0, 1'b0);
      add_size(12'd1, 13'd1);
      add_word(mnde_pkg::OP_PIXEL, 8'd200, 1'b0, 8'd0, 1'b0);
      add_word(mnde_pkg::OP_PIXEL, 8'd17, 1'b0, 8'd0, 1'b0);
      add_word(mnde_pkg::OP_DRAIN, 8'h00, 1'b0, 8'd0, 1'b0);
      add_word(mnde_pkg::OP_DRAIN, 8'hFF, 1'b1, 8'd0, 1'b1);
      add_size(12'd0, 13'd0);
      add_word(mnde_pkg::OP_DRAIN, 8'd3, 1'b0, 8'd0, 1'b0);
      add_word(mnde_pkg::OP_PIXEL, 8'd99, 1'b0, 8'd0, 1'b0);
      add_word(mnde_pkg::OP_DRAIN, 8'h00, 1'b0, 8'd0, 1'b0);
      add_word(mnde_pkg::OP_DRAIN, 8'h00, 1'b1, 8'd0, 1'b1);
      add_size(12'd3, 13'd3);
      for (k = 0; k < 9; k++)
         add_word(mnde_pkg::OP_PIXEL, (((k / 3) + (k % 3)) % 2 == 1) ? 8'hFF : 8'h00,
                  k >= 4, 8'd255, 1'b0);
      add_word(mnde_pkg::OP_PIXEL, 8'd128, 1'b0, 8'd0, 1'b0);
      for (k = 9; k < 13; k++)
         add_word(mnde_pkg::OP_DRAIN, 8'h00, 1'b1, 8'd255, k == 12);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_SIZE)
            set_frame_size(dir_rows[i].width_val, dir_rows[i].height_val);
         else
            send_word(dir_rows[i].op, dir_rows[i].pix, 1'b1, dir_rows[i].has_res,
                      dir_rows[i].mag, dir_rows[i].last);
      end

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pcts[p];
         stall_pct     = stall_pcts[p];
         if (p == 0) begin
            // hold the result side off so the queue fills and input backs up
            set_frame_size(24, 6);
            fork
               begin
                  hold_rsp <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  hold_rsp <= 1'b0;
               end
            join_none
            run_frame(24, 6, 1'b0);
         end
         target = words_used + PHASE_WORDS;
         resize = 1'b1;
         while (words_used < target) begin
            if ($urandom_range(9) == 0) begin
               w = $urandom_range(13, 64);
               h = $urandom_range(1, 3);
            end else begin
               w = $urandom_range(0, 12);
               h = $urandom_range(0, 8);
            end
            run_frame(w, h, resize);
            resize = ($urandom_range(99) < 60);
         end
      end

      // drain what is still due, then watch for strays
      req_tvalid <= 1'b0;
      while (due_edges.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d words (%0d ignored) over %0d frames; checked %0d edge results",
               words_sent, words_sent - words_used, frames_done, results_seen);
      $display("Frame size writes: %0d, widths 0 to 64 and heights 0 to 8",
               size_writes);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### files.f
rtl/mnde_pkg.sv
rtl/mnde_line_store.sv
rtl/mnde_window.sv
rtl/mnde_out_fifo.sv
rtl/max_neighbor_difference_edge.sv
tb/tb_max_neighbor_difference_edge.sv
